/* rtl/mfas_pkg.sv */
package mfas_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int MAX_EDGES    = 256;

    localparam int END_W    = 6;
    localparam int TRANS_W  = 16;
    localparam int WGT_W    = 41;
    localparam int VWGT_W   = 48;
    localparam int TOTAL_W  = 9;
    localparam int IDX_W    = 8;
    localparam int VCNT_W   = 7;
    localparam int THR_W    = 47;
    localparam int DOT_W    = 34;
    localparam int SCORE_W  = 49;
    localparam int PROD_W   = 98;
    localparam int HALF_W   = 25;

    localparam logic [VWGT_W-1:0] SAT48 = {VWGT_W{1'b1}};
    localparam logic [SCORE_W-1:0] WEIGHT_ONE = SCORE_W'(64'd1 << 26);

    localparam logic REG_VERTEX_COUNT = 1'b0;
    localparam logic REG_THRESHOLD    = 1'b1;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_RUN   = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_RANGE = 2'd2
    } t_status;

    typedef enum logic [4:0] {
        ST_IDLE, ST_QRY, ST_VCLR,
        ST_W_RD, ST_W_LAT, ST_W_MUL, ST_W_WR,
        ST_W_VA_RD, ST_W_VA_WR, ST_W_VB_RD, ST_W_VB_WR,
        ST_S_START, ST_S_RD, ST_S_EVAL, ST_S_MUL, ST_S_CMP,
        ST_U_RD, ST_U_CHK, ST_U_A_RD, ST_U_A_WR, ST_U_B_RD, ST_U_B_WR,
        ST_P_RD, ST_P_WR,
        ST_B_RD, ST_B_CHK, ST_B_RA, ST_B_RB, ST_B_WR,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [END_W-1:0]          end_lo;
        logic [END_W-1:0]          end_hi;
        logic signed [TRANS_W-1:0] tx;
        logic signed [TRANS_W-1:0] ty;
        logic signed [TRANS_W-1:0] tz;
        logic [WGT_W-1:0]          weight;
        logic                      flipped;
        logic [VWGT_W-1:0]         broken;
    } t_edge;

    function automatic logic [VWGT_W-1:0] sat_add(input logic [VWGT_W-1:0] a,
                                                  input logic [VWGT_W-1:0] b);
        logic [VWGT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[VWGT_W] ? SAT48 : s[VWGT_W-1:0];
    endfunction

    function automatic logic [VWGT_W-1:0] floor_sub(input logic [VWGT_W-1:0] a,
                                                    input logic [VWGT_W-1:0] b);
        return (a > b) ? (a - b) : '0;
    endfunction

endpackage

/* rtl/mfas_translation_edge_rejector_unit.sv */
// Channel   Direction  Handshake                  Payload
// request   in         i_in_valid / o_in_stall    command, vertices, translation, direction, index
// result    out        o_out_valid / i_out_stall  status, edge_total, broken_weight, is_outlier
// config    in         i_cfg_we                   i_cfg_index, i_cfg_data
//
// A query makes one edge memory read.
// A run's length is set by read-modify-write through the one-read-port vertex memory and
// by the 8-step score multiply (four 25x25 partial products each side).
// Reset is synchronous and active low; it empties the edge store and restores the registers.
// One request is in flight at a time; a stalled waiting result blocks the next request.
module mfas_translation_edge_rejector_unit
    import mfas_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_index,
    input  logic [THR_W-1:0]          i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [1:0]                i_command,
    input  logic [END_W-1:0]          i_source_vertex,
    input  logic [END_W-1:0]          i_target_vertex,
    input  logic signed [TRANS_W-1:0] i_trans_x,
    input  logic signed [TRANS_W-1:0] i_trans_y,
    input  logic signed [TRANS_W-1:0] i_trans_z,
    input  logic signed [TRANS_W-1:0] i_dir_x,
    input  logic signed [TRANS_W-1:0] i_dir_y,
    input  logic signed [TRANS_W-1:0] i_dir_z,
    input  logic [IDX_W-1:0]          i_edge_index,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [1:0]                o_status,
    output logic [TOTAL_W-1:0]        o_edge_total,
    output logic [VWGT_W-1:0]         o_broken_weight,
    output logic                      o_is_outlier
);

    localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW = $clog2(MAX_EDGES + 1);
    localparam int VW = $clog2(MAX_VERTICES);
    localparam int NW = $clog2(MAX_VERTICES + 1);

    typedef struct packed {
        logic [VWGT_W-1:0] in_w;
        logic [VWGT_W-1:0] out_w;
        logic [VW-1:0]     pos;
        logic              chosen;
    } t_vtx;

    t_edge r_emem [MAX_EDGES];
    t_vtx  r_vmem [MAX_VERTICES];

    logic          e_we;
    logic [EW-1:0] e_waddr, e_raddr;
    t_edge         e_wdata, r_erd;
    logic          v_we;
    logic [VW-1:0] v_waddr, v_raddr;
    t_vtx          v_wdata, r_vrd;

    always_ff @(posedge i_clk) begin
        if (e_we) begin
            r_emem[e_waddr] <= e_wdata;
        end
        r_erd <= r_emem[e_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (v_we) begin
            r_vmem[v_waddr] <= v_wdata;
        end
        r_vrd <= r_vmem[v_raddr];
    end

    t_state                    r_state, n_state;
    logic [CW-1:0]             r_cnt, n_cnt;
    logic [VCNT_W-1:0]         r_vcnt, n_vcnt;
    logic [THR_W-1:0]          r_thr, n_thr;
    logic                      r_ov, n_ov;

    logic [CW-1:0]             r_e, n_e;
    logic [NW-1:0]             r_v, n_v, r_step, n_step, r_n, n_n;
    logic [2:0]                r_k, n_k;
    logic signed [DOT_W-1:0]   r_acc, n_acc;
    logic signed [TRANS_W-1:0] r_dx, n_dx, r_dy, n_dy, r_dz, n_dz;
    t_edge                     r_ent, n_ent;
    logic [END_W-1:0]          r_ea, n_ea, r_eb, n_eb;
    logic [WGT_W-1:0]          r_w, n_w;
    logic [VW-1:0]             r_choice, n_choice, r_pa, n_pa;
    logic                      r_have, n_have;
    logic [SCORE_W-1:0]        r_bin1, n_bin1, r_bout1, n_bout1;
    logic [SCORE_W-1:0]        r_cin1, n_cin1, r_cout1, n_cout1;
    logic [PROD_W-1:0]         r_p1, n_p1, r_p2, n_p2;
    logic [IDX_W-1:0]          r_idx, n_idx;
    logic [1:0]                r_status, n_status;
    logic [TOTAL_W-1:0]        r_total, n_total;
    logic [VWGT_W-1:0]         r_bw, n_bw;
    logic                      r_outl, n_outl;

    logic                      in_acc;
    logic signed [TRANS_W-1:0] sel_t, sel_d;
    logic signed [DOT_W-1:0]   dot_mag;
    logic [SCORE_W-1:0]        mx, my;
    logic [HALF_W-1:0]         xs, ys;
    logic [2*HALF_W-1:0]       pp;
    logic [PROD_W-1:0]         pp_sh;
    logic [END_W-1:0]          ca, cb;
    logic                      out_rng;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE) || (r_ov && i_out_stall);

    assign o_out_valid     = r_ov;
    assign o_status        = r_status;
    assign o_edge_total    = r_total;
    assign o_broken_weight = r_bw;
    assign o_is_outlier    = r_outl;

    // Edge ends oriented by the stored flip, from the edge memory read data.
    assign ca = r_erd.flipped ? r_erd.end_hi : r_erd.end_lo;
    assign cb = r_erd.flipped ? r_erd.end_lo : r_erd.end_hi;
    assign out_rng = (32'(ca) >= 32'(r_n)) || (32'(cb) >= 32'(r_n));

    // Dot product: one signed 16x16 product per cycle.
    always_comb begin
        case (r_k)
            3'd0:    begin sel_t = r_ent.tx; sel_d = r_dx; end
            3'd1:    begin sel_t = r_ent.ty; sel_d = r_dy; end
            default: begin sel_t = r_ent.tz; sel_d = r_dz; end
        endcase
    end
    assign dot_mag = (r_acc < 0) ? -r_acc : r_acc;

    // Score products (out_c+1)*(in_b+1) then (out_b+1)*(in_c+1), one partial per cycle.
    assign mx = r_k[2] ? r_bout1 : r_cout1;
    assign my = r_k[2] ? r_cin1  : r_bin1;
    assign xs = r_k[1] ? HALF_W'(mx[SCORE_W-1:HALF_W]) : mx[HALF_W-1:0];
    assign ys = r_k[0] ? HALF_W'(my[SCORE_W-1:HALF_W]) : my[HALF_W-1:0];
    assign pp = xs * ys;
    always_comb begin
        case ({r_k[1], r_k[0]})
            2'b00:   pp_sh = PROD_W'(pp);
            2'b11:   pp_sh = PROD_W'(pp) << (2 * HALF_W);
            default: pp_sh = PROD_W'(pp) << HALF_W;
        endcase
    end

    always_comb begin
        n_state  = r_state;  n_cnt   = r_cnt;
        n_vcnt   = r_vcnt;   n_thr   = r_thr;   n_ov     = r_ov;
        n_e      = r_e;      n_v     = r_v;     n_step   = r_step;
        n_n      = r_n;      n_k     = r_k;     n_acc    = r_acc;
        n_dx     = r_dx;     n_dy    = r_dy;    n_dz     = r_dz;
        n_ent    = r_ent;    n_ea    = r_ea;    n_eb     = r_eb;
        n_w      = r_w;      n_choice = r_choice; n_pa   = r_pa;
        n_have   = r_have;   n_bin1  = r_bin1;  n_bout1  = r_bout1;
        n_cin1   = r_cin1;   n_cout1 = r_cout1; n_p1     = r_p1;
        n_p2     = r_p2;     n_idx   = r_idx;   n_status = r_status;
        n_total  = r_total;  n_bw    = r_bw;    n_outl   = r_outl;

        e_we    = 1'b0;
        e_waddr = EW'(r_e);
        e_raddr = EW'(r_e);
        e_wdata = r_ent;
        v_we    = 1'b0;
        v_waddr = VW'(r_ea);
        v_raddr = VW'(r_ea);
        v_wdata = r_vrd;

        if (r_ov && !i_out_stall) begin
            n_ov = 1'b0;
        end

        if (i_cfg_we) begin
            case (i_cfg_index)
                REG_VERTEX_COUNT: n_vcnt = i_cfg_data[VCNT_W-1:0];
                REG_THRESHOLD:    n_thr  = i_cfg_data;
                default:          n_thr  = r_thr;
            endcase
        end

        case (r_state)
            ST_IDLE: begin
                e_raddr = EW'(i_edge_index);
                if (in_acc) begin
                    n_status = STS_OK;
                    n_bw     = '0;
                    n_outl   = 1'b0;
                    case (t_cmd'(i_command))
                        CMD_LOAD: begin
                            if (32'(r_cnt) >= MAX_EDGES) begin
                                n_status = STS_FULL;
                            end else begin
                                e_we    = 1'b1;
                                e_waddr = EW'(r_cnt);
                                e_wdata.end_lo = (i_source_vertex < i_target_vertex) ?
                                                 i_source_vertex : i_target_vertex;
                                e_wdata.end_hi = (i_source_vertex < i_target_vertex) ?
                                                 i_target_vertex : i_source_vertex;
                                e_wdata.tx      = i_trans_x;
                                e_wdata.ty      = i_trans_y;
                                e_wdata.tz      = i_trans_z;
                                e_wdata.weight  = '0;
                                e_wdata.flipped = 1'b0;
                                e_wdata.broken  = '0;
                                n_cnt = r_cnt + CW'(1);
                            end
                            n_total = TOTAL_W'(n_cnt);
                            n_ov    = 1'b1;
                        end
                        CMD_RUN: begin
                            n_dx = i_dir_x;
                            n_dy = i_dir_y;
                            n_dz = i_dir_z;
                            n_n  = (32'(r_vcnt) < MAX_VERTICES) ? NW'(r_vcnt)
                                                                : NW'(MAX_VERTICES);
                            n_v  = '0;
                            n_state = ST_VCLR;
                        end
                        CMD_QUERY: begin
                            n_idx   = i_edge_index;
                            n_state = ST_QRY;
                        end
                        default: begin
                            n_cnt   = '0;
                            n_total = '0;
                            n_ov    = 1'b1;
                        end
                    endcase
                end
            end

            ST_QRY: begin
                n_total = TOTAL_W'(r_cnt);
                if (32'(r_idx) >= 32'(r_cnt)) begin
                    n_status = STS_RANGE;
                end else begin
                    n_bw   = r_erd.broken;
                    n_outl = (r_erd.broken >= VWGT_W'(r_thr));
                end
                n_ov    = 1'b1;
                n_state = ST_IDLE;
            end

            ST_VCLR: begin
                v_we    = 1'b1;
                v_waddr = VW'(r_v);
                v_wdata = '0;
                n_v     = r_v + NW'(1);
                if (r_v == NW'(MAX_VERTICES - 1)) begin
                    n_e      = '0;
                    n_state  = ST_W_RD;
                end
            end

            // Projection pass: weight and flip of every edge, then vertex sums.
            ST_W_RD: begin
                if (r_e == r_cnt) begin
                    n_step  = '0;
                    n_state = ST_S_START;
                end else begin
                    n_state = ST_W_LAT;
                end
            end
            ST_W_LAT: begin
                n_ent   = r_erd;
                n_k     = '0;
                n_acc   = '0;
                n_state = ST_W_MUL;
            end
            ST_W_MUL: begin
                n_acc = r_acc + DOT_W'(sel_t * sel_d);
                n_k   = r_k + 3'd1;
                if (r_k == 3'd2) begin
                    n_state = ST_W_WR;
                end
            end
            ST_W_WR: begin
                e_we            = 1'b1;
                e_wdata.flipped = (r_acc < 0);
                e_wdata.weight  = WGT_W'(dot_mag);
                n_w  = WGT_W'(dot_mag);
                n_ea = (r_acc < 0) ? r_ent.end_hi : r_ent.end_lo;
                n_eb = (r_acc < 0) ? r_ent.end_lo : r_ent.end_hi;
                if ((32'(n_ea) >= 32'(r_n)) || (32'(n_eb) >= 32'(r_n))) begin
                    n_e     = r_e + CW'(1);
                    n_state = ST_W_RD;
                end else begin
                    n_state = ST_W_VA_RD;
                end
            end
            ST_W_VA_RD: begin
                n_state = ST_W_VA_WR;
            end
            ST_W_VA_WR: begin
                v_we          = 1'b1;
                v_wdata.out_w = sat_add(r_vrd.out_w, VWGT_W'(r_w));
                n_state       = ST_W_VB_RD;
            end
            ST_W_VB_RD: begin
                v_raddr = VW'(r_eb);
                n_state = ST_W_VB_WR;
            end
            ST_W_VB_WR: begin
                v_we         = 1'b1;
                v_waddr      = VW'(r_eb);
                v_wdata.in_w = sat_add(r_vrd.in_w, VWGT_W'(r_w));
                n_e          = r_e + CW'(1);
                n_state      = ST_W_RD;
            end

            // Greedy order: one choice per step.
            ST_S_START: begin
                n_v    = '0;
                n_have = 1'b0;
                n_e    = '0;
                n_state = (r_step == r_n) ? ST_B_RD : ST_S_RD;
            end
            ST_S_RD: begin
                v_raddr = VW'(r_v);
                if (r_v == r_n) begin
                    n_state = ST_U_RD;
                end else begin
                    n_state = ST_S_EVAL;
                end
            end
            ST_S_EVAL: begin
                if (r_vrd.chosen) begin
                    n_v     = r_v + NW'(1);
                    n_state = ST_S_RD;
                end else if (r_vrd.in_w == '0) begin
                    // A source wins at once.
                    n_choice = VW'(r_v);
                    n_state  = ST_U_RD;
                end else if (!r_have) begin
                    n_choice = VW'(r_v);
                    n_have   = 1'b1;
                    n_bin1   = SCORE_W'(r_vrd.in_w) + WEIGHT_ONE;
                    n_bout1  = SCORE_W'(r_vrd.out_w) + WEIGHT_ONE;
                    n_v      = r_v + NW'(1);
                    n_state  = ST_S_RD;
                end else begin
                    n_cin1  = SCORE_W'(r_vrd.in_w) + WEIGHT_ONE;
                    n_cout1 = SCORE_W'(r_vrd.out_w) + WEIGHT_ONE;
                    n_p1    = '0;
                    n_p2    = '0;
                    n_k     = '0;
                    n_state = ST_S_MUL;
                end
            end
            ST_S_MUL: begin
                if (r_k[2]) begin
                    n_p2 = r_p2 + pp_sh;
                end else begin
                    n_p1 = r_p1 + pp_sh;
                end
                n_k = r_k + 3'd1;
                if (r_k == 3'd7) begin
                    n_state = ST_S_CMP;
                end
            end
            ST_S_CMP: begin
                if (r_p1 > r_p2) begin
                    n_choice = VW'(r_v);
                    n_bin1   = r_cin1;
                    n_bout1  = r_cout1;
                end
                n_v     = r_v + NW'(1);
                n_state = ST_S_RD;
            end

            // Remove the chosen vertex's edges from the remaining sums, then mark it chosen at its step position.
            ST_U_RD: begin
                n_state = (r_e == r_cnt) ? ST_P_RD : ST_U_CHK;
            end
            ST_U_CHK: begin
                n_ea = ca;
                n_eb = cb;
                n_w  = r_erd.weight;
                if (out_rng) begin
                    n_e     = r_e + CW'(1);
                    n_state = ST_U_RD;
                end else if (VW'(cb) == r_choice) begin
                    n_state = ST_U_A_RD;
                end else if (VW'(ca) == r_choice) begin
                    n_state = ST_U_B_RD;
                end else begin
                    n_e     = r_e + CW'(1);
                    n_state = ST_U_RD;
                end
            end
            ST_U_A_RD: begin
                n_state = ST_U_A_WR;
            end
            ST_U_A_WR: begin
                v_we          = 1'b1;
                v_wdata.out_w = floor_sub(r_vrd.out_w, VWGT_W'(r_w));
                if (VW'(r_ea) == r_choice) begin
                    n_state = ST_U_B_RD;
                end else begin
                    n_e     = r_e + CW'(1);
                    n_state = ST_U_RD;
                end
            end
            ST_U_B_RD: begin
                v_raddr = VW'(r_eb);
                n_state = ST_U_B_WR;
            end
            ST_U_B_WR: begin
                v_we         = 1'b1;
                v_waddr      = VW'(r_eb);
                v_wdata.in_w = floor_sub(r_vrd.in_w, VWGT_W'(r_w));
                n_e          = r_e + CW'(1);
                n_state      = ST_U_RD;
            end
            ST_P_RD: begin
                v_raddr = r_choice;
                n_state = ST_P_WR;
            end
            ST_P_WR: begin
                v_we           = 1'b1;
                v_waddr        = r_choice;
                v_wdata.pos    = VW'(r_step);
                v_wdata.chosen = 1'b1;
                n_step  = r_step + NW'(1);
                n_state = ST_S_START;
            end

            // Backward edges in the final order gain their weight.
            ST_B_RD: begin
                n_state = (r_e == r_cnt) ? ST_DONE : ST_B_CHK;
            end
            ST_B_CHK: begin
                n_ent = r_erd;
                n_ea  = ca;
                n_eb  = cb;
                if (out_rng || (r_erd.weight == '0)) begin
                    n_e     = r_e + CW'(1);
                    n_state = ST_B_RD;
                end else begin
                    n_state = ST_B_RA;
                end
            end
            ST_B_RA: begin
                n_state = ST_B_RB;
            end
            ST_B_RB: begin
                n_pa    = r_vrd.pos;
                v_raddr = VW'(r_eb);
                n_state = ST_B_WR;
            end
            ST_B_WR: begin
                if (r_vrd.pos < r_pa) begin
                    e_we           = 1'b1;
                    e_wdata.broken = sat_add(r_ent.broken, VWGT_W'(r_ent.weight));
                end
                n_e     = r_e + CW'(1);
                n_state = ST_B_RD;
            end

            ST_DONE: begin
                n_status = STS_OK;
                n_total  = TOTAL_W'(r_cnt);
                n_bw     = '0;
                n_outl   = 1'b0;
                n_ov     = 1'b1;
                n_state  = ST_IDLE;
            end

            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_vcnt   <= VCNT_W'(64);
            r_thr    <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_vcnt   <= n_vcnt;
            r_thr    <= n_thr;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e      <= n_e;      r_v     <= n_v;     r_step   <= n_step;
        r_n      <= n_n;      r_k     <= n_k;     r_acc    <= n_acc;
        r_dx     <= n_dx;     r_dy    <= n_dy;    r_dz     <= n_dz;
        r_ent    <= n_ent;    r_ea    <= n_ea;    r_eb     <= n_eb;
        r_w      <= n_w;      r_choice <= n_choice; r_pa   <= n_pa;
        r_have   <= n_have;   r_bin1  <= n_bin1;  r_bout1  <= n_bout1;
        r_cin1   <= n_cin1;   r_cout1 <= n_cout1; r_p1     <= n_p1;
        r_p2     <= n_p2;     r_idx   <= n_idx;   r_status <= n_status;
        r_total  <= n_total;  r_bw    <= n_bw;    r_outl   <= n_outl;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) <= MAX_EDGES)
        else $error("edge count exceeds store depth");

    a_load_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_command == CMD_LOAD) && (32'(r_cnt) < MAX_EDGES)
        |=> r_cnt == $past(r_cnt) + CW'(1))
        else $error("accepted load did not grow the store");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_S_RD) |-> (r_step < r_n))
        else $error("greedy step beyond vertex count");

    a_choice_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_P_WR) |-> !r_vrd.chosen)
        else $error("vertex chosen twice");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> ($past(r_state) == ST_IDLE || $past(r_state) == ST_QRY
                         || $past(r_state) == ST_DONE))
        else $error("result raised outside a finishing state");

endmodule

/* verif/mfas_translation_edge_rejector_checker.sv */
module mfas_translation_edge_rejector_checker
    import mfas_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_index,
    input  logic [THR_W-1:0]          i_cfg_data,
    input  logic                      i_in_valid,
    input  logic                      o_in_stall,
    input  logic [1:0]                i_command,
    input  logic [END_W-1:0]          i_source_vertex,
    input  logic [END_W-1:0]          i_target_vertex,
    input  logic signed [TRANS_W-1:0] i_trans_x,
    input  logic signed [TRANS_W-1:0] i_trans_y,
    input  logic signed [TRANS_W-1:0] i_trans_z,
    input  logic signed [TRANS_W-1:0] i_dir_x,
    input  logic signed [TRANS_W-1:0] i_dir_y,
    input  logic signed [TRANS_W-1:0] i_dir_z,
    input  logic [IDX_W-1:0]          i_edge_index,
    input  logic                      o_out_valid,
    input  logic                      i_out_stall,
    input  logic [1:0]                o_status,
    input  logic [TOTAL_W-1:0]        o_edge_total,
    input  logic [VWGT_W-1:0]         o_broken_weight,
    input  logic                      o_is_outlier,
    output int                        o_mismatches,
    output int                        o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int EDGES = 256;
    localparam int VERTS = 64;

    typedef struct {
        t_status            status;
        logic [TOTAL_W-1:0] total;
        logic [VWGT_W-1:0]  weight;
        logic               outlier;
    } t_edge_result;

    t_edge_result pending_results[$];

    logic [END_W-1:0]          end_lo [EDGES];
    logic [END_W-1:0]          end_hi [EDGES];
    logic signed [TRANS_W-1:0] tr_x [EDGES];
    logic signed [TRANS_W-1:0] tr_y [EDGES];
    logic signed [TRANS_W-1:0] tr_z [EDGES];
    logic [VWGT_W-1:0]         broken_acc [EDGES];
    int                        loaded_edges;
    logic [VCNT_W-1:0]         vertex_limit;
    logic [THR_W-1:0]          outlier_threshold;
    int                        mismatch_count;

    function automatic logic [VWGT_W-1:0] clamp_add(input logic [VWGT_W-1:0] x,
                                                    input logic [VWGT_W-1:0] y);
        logic [VWGT_W:0] s;
        s = {1'b0, x} + {1'b0, y};
        return s[VWGT_W] ? {VWGT_W{1'b1}} : s[VWGT_W-1:0];
    endfunction

    // One direction pass: project, orient, greedy order, then charge backward edges.
    task automatic project_and_rank(input logic signed [TRANS_W-1:0] dx,
                                    input logic signed [TRANS_W-1:0] dy,
                                    input logic signed [TRANS_W-1:0] dz);
        int                n, e, v, step, choice;
        bit                have;
        longint            dot;
        logic [VWGT_W-1:0] wgt [EDGES];
        int                tail [EDGES];
        int                head [EDGES];
        logic [VWGT_W-1:0] in_w [VERTS];
        logic [VWGT_W-1:0] out_w [VERTS];
        bit                chosen [VERTS];
        int                rank [VERTS];
        logic [97:0]       lhs, rhs, one;
        one = 98'(1) << 26;
        n = (vertex_limit < VERTS) ? int'(vertex_limit) : VERTS;
        for (v = 0; v < VERTS; v++) begin
            in_w[v] = '0;
            out_w[v] = '0;
            chosen[v] = 1'b0;
            rank[v] = 0;
        end
        for (e = 0; e < loaded_edges; e++) begin
            dot = longint'(tr_x[e]) * longint'(dx) + longint'(tr_y[e]) * longint'(dy)
                + longint'(tr_z[e]) * longint'(dz);
            wgt[e] = (dot < 0) ? VWGT_W'(-dot) : VWGT_W'(dot);
            tail[e] = (dot < 0) ? int'(end_hi[e]) : int'(end_lo[e]);
            head[e] = (dot < 0) ? int'(end_lo[e]) : int'(end_hi[e]);
            if (tail[e] < n && head[e] < n) begin
                out_w[tail[e]] = clamp_add(out_w[tail[e]], wgt[e]);
                in_w[head[e]] = clamp_add(in_w[head[e]], wgt[e]);
            end
        end
        for (step = 0; step < n; step++) begin
            choice = 0;
            have = 1'b0;
            for (v = 0; v < n; v++) begin
                if (chosen[v]) continue;
                if (in_w[v] == 0) begin
                    choice = v;
                    break;
                end
                lhs = (98'(out_w[v]) + one) * (98'(in_w[choice]) + one);
                rhs = (98'(out_w[choice]) + one) * (98'(in_w[v]) + one);
                if (!have || lhs > rhs) begin
                    choice = v;
                    have = 1'b1;
                end
            end
            for (e = 0; e < loaded_edges; e++) begin
                if (tail[e] >= n || head[e] >= n) continue;
                if (head[e] == choice)
                    out_w[tail[e]] = (out_w[tail[e]] > wgt[e]) ? out_w[tail[e]] - wgt[e] : '0;
                if (tail[e] == choice)
                    in_w[head[e]] = (in_w[head[e]] > wgt[e]) ? in_w[head[e]] - wgt[e] : '0;
            end
            rank[choice] = step;
            chosen[choice] = 1'b1;
        end
        for (e = 0; e < loaded_edges; e++) begin
            if (tail[e] >= n || head[e] >= n) continue;
            if (wgt[e] > 0 && rank[head[e]] < rank[tail[e]])
                broken_acc[e] = clamp_add(broken_acc[e], wgt[e]);
        end
    endtask

    task automatic predict_request();
        t_edge_result r;
        int           i;
        r.status = STS_OK;
        r.weight = '0;
        r.outlier = 1'b0;
        case (t_cmd'(i_command))
            CMD_LOAD: begin
                if (loaded_edges >= EDGES) begin
                    r.status = STS_FULL;
                end else begin
                    end_lo[loaded_edges] = (i_source_vertex < i_target_vertex) ?
                                           i_source_vertex : i_target_vertex;
                    end_hi[loaded_edges] = (i_source_vertex < i_target_vertex) ?
                                           i_target_vertex : i_source_vertex;
                    tr_x[loaded_edges] = i_trans_x;
                    tr_y[loaded_edges] = i_trans_y;
                    tr_z[loaded_edges] = i_trans_z;
                    broken_acc[loaded_edges] = '0;
                    loaded_edges++;
                end
            end
            CMD_RUN: project_and_rank(i_dir_x, i_dir_y, i_dir_z);
            CMD_QUERY: begin
                if (int'(i_edge_index) >= loaded_edges) begin
                    r.status = STS_RANGE;
                end else begin
                    r.weight = broken_acc[i_edge_index];
                    r.outlier = (r.weight >= {1'b0, outlier_threshold});
                end
            end
            default: begin
                loaded_edges = 0;
                for (i = 0; i < EDGES; i++) broken_acc[i] = '0;
            end
        endcase
        r.total = TOTAL_W'(loaded_edges);
        pending_results.insert(pending_results.size(), r);
    endtask

    task automatic compare_result();
        t_edge_result r;
        if (pending_results.size() == 0) begin
            $error("unexpected result: status %0d total %0d", o_status, o_edge_total);
            mismatch_count++;
            return;
        end
        r = pending_results.pop_front();
        if (o_status !== r.status) begin
            $error("status: expected %0d, got %0d", r.status, o_status);
            mismatch_count++;
        end
        if (o_edge_total !== r.total) begin
            $error("edge_total: expected %0d, got %0d", r.total, o_edge_total);
            mismatch_count++;
        end
        if (o_broken_weight !== r.weight) begin
            $error("broken_weight: expected %0d, got %0d", r.weight, o_broken_weight);
            mismatch_count++;
        end
        if (o_is_outlier !== r.outlier) begin
            $error("is_outlier: expected %0d, got %0d", r.outlier, o_is_outlier);
            mismatch_count++;
        end
    endtask

    initial begin
        mismatch_count = 0;
        loaded_edges = 0;
        vertex_limit = 7'd64;
        outlier_threshold = '0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            loaded_edges = 0;
            vertex_limit = 7'd64;
            outlier_threshold = '0;
            for (int i = 0; i < EDGES; i++) broken_acc[i] = '0;
            pending_results.delete();
        end else begin
            if (o_out_valid && !i_out_stall) compare_result();
            if (i_in_valid && !o_in_stall) predict_request();
            if (i_cfg_we) begin
                if (i_cfg_index == REG_VERTEX_COUNT) vertex_limit = i_cfg_data[VCNT_W-1:0];
                else outlier_threshold = i_cfg_data;
            end
        end
        o_mismatches <= mismatch_count;
        o_outstanding <= pending_results.size();
    end

endmodule

/* verif/mfas_translation_edge_rejector_unit_test.sv */
module mfas_translation_edge_rejector_unit_test;
    import mfas_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 500000;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic                      i_cfg_index;
    logic [THR_W-1:0]          i_cfg_data;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic [1:0]                i_command;
    logic [END_W-1:0]          i_source_vertex;
    logic [END_W-1:0]          i_target_vertex;
    logic signed [TRANS_W-1:0] i_trans_x;
    logic signed [TRANS_W-1:0] i_trans_y;
    logic signed [TRANS_W-1:0] i_trans_z;
    logic signed [TRANS_W-1:0] i_dir_x;
    logic signed [TRANS_W-1:0] i_dir_y;
    logic signed [TRANS_W-1:0] i_dir_z;
    logic [IDX_W-1:0]          i_edge_index;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic [1:0]                o_status;
    logic [TOTAL_W-1:0]        o_edge_total;
    logic [VWGT_W-1:0]         o_broken_weight;
    logic                      o_is_outlier;
    int                        o_mismatches;
    int                        o_outstanding;

    int idle_pct;
    int stall_pct;
    int quiet_cycles;
    int active_vertices;

    mfas_translation_edge_rejector_unit uut (.*);
    mfas_translation_edge_rejector_checker checker_inst (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) i_out_stall <= ($urandom_range(99) < stall_pct);

    // Ends the run if the block stops taking requests or returning results.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [15:0] rnd16();
        return 16'($urandom);
    endfunction

    task automatic send(input t_cmd cmd, input logic [END_W-1:0] s, input logic [END_W-1:0] t,
                        input logic [15:0] x, input logic [15:0] y, input logic [15:0] z,
                        input logic [15:0] dx, input logic [15:0] dy, input logic [15:0] dz,
                        input logic [IDX_W-1:0] idx);
        int gap;
        gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_command <= cmd;
        i_source_vertex <= s;
        i_target_vertex <= t;
        i_trans_x <= x;
        i_trans_y <= y;
        i_trans_z <= z;
        i_dir_x <= dx;
        i_dir_y <= dy;
        i_dir_z <= dz;
        i_edge_index <= idx;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic load_edge(input int s, input int t, input int x, input int y, input int z);
        send(CMD_LOAD, END_W'(s), END_W'(t), 16'(x), 16'(y), 16'(z),
             rnd16(), rnd16(), rnd16(), IDX_W'($urandom));
    endtask

    task automatic run_direction(input int dx, input int dy, input int dz);
        send(CMD_RUN, END_W'($urandom), END_W'($urandom), rnd16(), rnd16(), rnd16(),
             16'(dx), 16'(dy), 16'(dz), IDX_W'($urandom));
    endtask

    task automatic query_edge(input int idx);
        send(CMD_QUERY, END_W'($urandom), END_W'($urandom), rnd16(), rnd16(), rnd16(),
             rnd16(), rnd16(), rnd16(), IDX_W'(idx));
    endtask

    task automatic clear_store();
        send(CMD_CLEAR, END_W'($urandom), END_W'($urandom), rnd16(), rnd16(), rnd16(),
             rnd16(), rnd16(), rnd16(), IDX_W'($urandom));
    endtask

    function automatic int random_dir();
        return int'($urandom_range(32768)) - 16384;
    endfunction

    // Drain every outstanding result before touching the registers.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (o_outstanding != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [THR_W-1:0] data);
        i_cfg_index <= idx;
        i_cfg_data <= data;
        i_cfg_we <= 1'b1;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == REG_VERTEX_COUNT) active_vertices = int'(data[VCNT_W-1:0]);
    endtask

    task automatic random_sequence();
        int k;
        int s;
        int t;
        logic [THR_W-1:0] thr;
        drain();
        write_reg(REG_VERTEX_COUNT, THR_W'($urandom_range(2, 12)));
        case ($urandom_range(3))
            0: thr = '0;
            1: thr = {THR_W{1'b1}};
            default: thr = THR_W'({$urandom, $urandom}) >> $urandom_range(12, 40);
        endcase
        write_reg(REG_THRESHOLD, thr);
        if ($urandom_range(9) != 0) clear_store();
        k = $urandom_range(1, 10);
        repeat (k) begin
            if ($urandom_range(99) < 85) begin
                s = $urandom_range(active_vertices - 1);
                t = $urandom_range(active_vertices - 1);
            end else begin
                s = $urandom_range(63);
                t = $urandom_range(63);
            end
            load_edge(s, t, $urandom, $urandom, $urandom);
        end
        repeat ($urandom_range(1, 3)) run_direction(random_dir(), random_dir(), random_dir());
        repeat ($urandom_range(2, 5)) begin
            if ($urandom_range(9) == 0) query_edge($urandom_range(255));
            else query_edge($urandom_range(k + 1));
        end
        // Occasionally a stray request out of the usual order.
        if ($urandom_range(4) == 0) begin
            case ($urandom_range(3))
                0: load_edge($urandom_range(63), $urandom_range(63), $urandom, $urandom, $urandom);
                1: run_direction(random_dir(), random_dir(), random_dir());
                2: query_edge($urandom_range(255));
                default: clear_store();
            endcase
        end
    endtask

    initial begin
        idle_pct = 0;
        stall_pct = 0;
        quiet_cycles = 0;
        active_vertices = 64;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = 1'b0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_command = CMD_LOAD;
        i_source_vertex = '0;
        i_target_vertex = '0;
        i_trans_x = '0;
        i_trans_y = '0;
        i_trans_z = '0;
        i_dir_x = '0;
        i_dir_y = '0;
        i_dir_z = '0;
        i_edge_index = '0;
        i_out_stall = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_reg(REG_VERTEX_COUNT, THR_W'(4));
        write_reg(REG_THRESHOLD, '0);
        query_edge(0);
        load_edge(3, 1, 32767, -32768, 0);
        load_edge(0, 2, -32768, 32767, 16384);
        load_edge(1, 2, 0, 0, 0);
        load_edge(2, 5, 4096, 4096, 4096);
        load_edge(0, 3, 100, -200, 300);
        run_direction(16384, 0, 0);
        run_direction(-16384, 16384, -16384);
        for (int i = 0; i < 5; i++) query_edge(i);
        query_edge(255);
        drain();
        write_reg(REG_THRESHOLD, {THR_W{1'b1}});
        query_edge(0);
        drain();
        write_reg(REG_VERTEX_COUNT, '0);
        run_direction(0, 0, 16384);
        query_edge(1);
        drain();
        write_reg(REG_VERTEX_COUNT, THR_W'(127));
        write_reg(REG_THRESHOLD, 47'd1 << 30);
        run_direction(16384, 16384, 16384);
        query_edge(0);
        clear_store();
        query_edge(0);

        for (int mode = 0; mode < 4; mode++) begin
            case (mode)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 69; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 69; end
                default: begin idle_pct = 36; stall_pct = 36; end
            endcase
            repeat (2) random_sequence();
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (o_mismatches == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

endmodule

/* files.f */
rtl/mfas_pkg.sv
rtl/mfas_translation_edge_rejector_unit.sv
verif/mfas_translation_edge_rejector_checker.sv
verif/mfas_translation_edge_rejector_unit_test.sv
